// File: hw/rtl/osc_message_parser_top_macros.svh
// Assertion macros shared by the parser's checking code.
`ifndef OSC_MESSAGE_PARSER_TOP_MACROS_SVH
`define OSC_MESSAGE_PARSER_TOP_MACROS_SVH

// Concurrent check on the rising clock, masked while reset is low.
`define OSC_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

// File: hw/rtl/osc_mp_pkg.sv
// Shared types, codes and constants for the OSC message parser.
package osc_mp_pkg;

	localparam int MaxTags   = 16;
	localparam int MaxPacket = 4096;
	localparam int PosW      = 13;
	localparam int TagIdxW   = 4;
	localparam int TagCntW   = 5;
	localparam int RemW      = 13;

	// Parse phases.
	localparam logic [3:0] PH_ADDR     = 4'd0;
	localparam logic [3:0] PH_ADDR_PAD = 4'd1;
	localparam logic [3:0] PH_TAGS     = 4'd2;
	localparam logic [3:0] PH_TAGS_PAD = 4'd3;
	localparam logic [3:0] PH_WORD     = 4'd4;
	localparam logic [3:0] PH_STR      = 4'd5;
	localparam logic [3:0] PH_DATA     = 4'd6;
	localparam logic [3:0] PH_ARG_PAD  = 4'd7;
	localparam logic [3:0] PH_DONE     = 4'd8;

	// Byte classes.
	localparam logic [3:0] CL_ADDR  = 4'd0;
	localparam logic [3:0] CL_SLASH = 4'd1;
	localparam logic [3:0] CL_PAD   = 4'd2;
	localparam logic [3:0] CL_TAG   = 4'd3;
	localparam logic [3:0] CL_INT   = 4'd4;
	localparam logic [3:0] CL_FLOAT = 4'd5;
	localparam logic [3:0] CL_STR   = 4'd6;
	localparam logic [3:0] CL_BSIZE = 4'd7;
	localparam logic [3:0] CL_BDATA = 4'd8;
	localparam logic [3:0] CL_IGN   = 4'd9;

	// Argument kinds.
	localparam logic [3:0] K_INT   = 4'd0;
	localparam logic [3:0] K_FLOAT = 4'd1;
	localparam logic [3:0] K_STR   = 4'd2;
	localparam logic [3:0] K_BLOB  = 4'd3;
	localparam logic [3:0] K_TRUE  = 4'd4;
	localparam logic [3:0] K_FALSE = 4'd5;
	localparam logic [3:0] K_NIL   = 4'd6;
	localparam logic [3:0] K_IMP   = 4'd7;
	localparam logic [3:0] K_UNS   = 4'd8;

	// Status codes.
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_BUNDLE    = 4'd1;
	localparam logic [3:0] ST_UNTERM    = 4'd2;
	localparam logic [3:0] ST_STR_PAD   = 4'd3;
	localparam logic [3:0] ST_EMPTY     = 4'd4;
	localparam logic [3:0] ST_BAD_TAGS  = 4'd5;
	localparam logic [3:0] ST_UNS_TAG   = 4'd6;
	localparam logic [3:0] ST_INT_SHORT = 4'd7;
	localparam logic [3:0] ST_NEG_BLOB  = 4'd8;
	localparam logic [3:0] ST_BLOB_SHORT = 4'd9;
	localparam logic [3:0] ST_BLOB_PAD  = 4'd10;
	localparam logic [3:0] ST_TOO_MANY  = 4'd11;

	typedef struct packed {
		logic [3:0]  status;
		logic [6:0]  address_part;
		logic        word_valid;
		logic [31:0] word_value;
		logic [3:0]  atom_kind;
		logic [3:0]  atom_index;
		logic [3:0]  byte_class;
	} res_t;

	function automatic logic [3:0] kind_of(input logic [7:0] c);
		case (c)
			8'h69: kind_of = K_INT;
			8'h66: kind_of = K_FLOAT;
			8'h73: kind_of = K_STR;
			8'h62: kind_of = K_BLOB;
			8'h54: kind_of = K_TRUE;
			8'h46: kind_of = K_FALSE;
			8'h4E: kind_of = K_NIL;
			8'h49: kind_of = K_IMP;
			default: kind_of = K_UNS;
		endcase
	endfunction

	// Characters of the bundle marker "#bundle".
	function automatic logic [7:0] bundle_char(input logic [2:0] p);
		case (p)
			3'd0: bundle_char = 8'h23;
			3'd1: bundle_char = 8'h62;
			3'd2: bundle_char = 8'h75;
			3'd3: bundle_char = 8'h6E;
			3'd4: bundle_char = 8'h64;
			3'd5: bundle_char = 8'h6C;
			3'd6: bundle_char = 8'h65;
			default: bundle_char = 8'h00;
		endcase
	endfunction

endpackage

// File: hw/rtl/osc_mp_core.sv
// Parser state and the per-byte decode that updates it.
module osc_mp_core import osc_mp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output res_t       res
);

	typedef struct packed {
		logic               found;
		logic [TagCntW-1:0] idx;
	} hit_t;

	logic [3:0]         ph_q, ph_n;
	logic [PosW-1:0]    pos_q, pos_n;
	logic [3:0]         store_q [MaxTags];
	logic [MaxTags-1:0] stop_q;
	logic [TagCntW-1:0] cnt_q, cnt_n;
	logic [TagCntW-1:0] cur_q, cur_n;
	logic [31:0]        ws_q, ws_n;
	logic [RemW-1:0]    rem_q, rem_n;
	logic [3:0]         err_q, err_n;
	logic [6:0]         seg_q, seg_n;
	logic [2:0]         bm_q, bm_n;
	logic               open_q, open_n;
	logic               aempty_q, aempty_n;
	logic               tbad_q, tbad_n;
	logic               tover_q, tover_n;
	logic               tstart_q, tstart_n;

	logic               wr_en;
	logic [3:0]         wr_kind;
	logic               end4, go_addr, go_tags, go_arg;
	logic [3:0]         fcode, ck, ek, cls, kind;
	logic [TagCntW-1:0] idx;
	logic [31:0]        val, w;
	logic               vld;
	hit_t               hit_zero, hit_next, hit;

	// First tag at or after start that takes bytes or is unsupported.
	function automatic hit_t find_stop(input logic [TagCntW-1:0] start,
			input logic [TagCntW-1:0] cnt, input logic [MaxTags-1:0] stop);
		hit_t h;
		h.found = 1'b0;
		h.idx   = cnt;
		for (int i = MaxTags - 1; i >= 0; i--) begin
			if (stop[i] && TagCntW'(i) >= start && TagCntW'(i) < cnt) begin
				h.found = 1'b1;
				h.idx   = TagCntW'(i);
			end
		end
		return h;
	endfunction

	assign hit_zero = find_stop('0, cnt_q, stop_q);
	assign hit_next = find_stop(cur_q + 1'b1, cnt_q, stop_q);

	always_comb begin
		ph_n = ph_q; pos_n = pos_q; cnt_n = cnt_q; cur_n = cur_q; ws_n = ws_q;
		rem_n = rem_q; err_n = err_q; seg_n = seg_q; bm_n = bm_q; open_n = open_q;
		aempty_n = aempty_q; tbad_n = tbad_q; tover_n = tover_q; tstart_n = tstart_q;
		wr_en = 1'b0; wr_kind = kind_of(data_byte);
		go_addr = 1'b0; go_tags = 1'b0; go_arg = 1'b0; fcode = ST_OK;
		cls = CL_IGN; idx = '0; kind = K_INT; val = '0; vld = 1'b0;
		w = {ws_q[23:0], data_byte};
		hit = hit_zero;
		ek = K_UNS;
		end4 = pos_q[1:0] == 2'b11;
		ck = (cur_q < cnt_q && cur_q < TagCntW'(MaxTags)) ? store_q[cur_q[TagIdxW-1:0]]
			: K_UNS;

		if (pos_q < PosW'(MaxPacket)) begin
			case (ph_q)
				PH_ADDR: begin
					if (data_byte == 8'h00) begin
						cls = CL_PAD;
						aempty_n = pos_q == '0;
						if (end4) go_addr = 1'b1; else ph_n = PH_ADDR_PAD;
					end else if (data_byte == 8'h2F) begin
						cls = CL_SLASH;
						open_n = 1'b0;
					end else begin
						cls = CL_ADDR;
						if (!open_q) begin
							open_n = 1'b1;
							if (seg_q != 7'd127) seg_n = seg_q + 1'b1;
						end
					end
					if (pos_q < PosW'(7) && PosW'(bm_q) == pos_q
							&& data_byte == bundle_char(pos_q[2:0])) begin
						bm_n = bm_q + 1'b1;
						if (bm_n == 3'd7) fcode = ST_BUNDLE;
					end
				end
				PH_ADDR_PAD: begin
					cls = CL_PAD;
					if (end4) go_addr = 1'b1;
				end
				PH_TAGS: begin
					if (data_byte == 8'h00) begin
						cls = CL_PAD;
						if (!tstart_q) tbad_n = 1'b1;
						if (end4) go_tags = 1'b1; else ph_n = PH_TAGS_PAD;
					end else begin
						cls = CL_TAG;
						if (!tstart_q) begin
							tstart_n = 1'b1;
							if (data_byte != 8'h2C) tbad_n = 1'b1;
						end else begin
							idx = cnt_q;
							kind = wr_kind;
							if (cnt_q < TagCntW'(MaxTags)) begin
								wr_en = 1'b1;
								cnt_n = cnt_q + 1'b1;
							end else begin
								tover_n = 1'b1;
							end
						end
					end
				end
				PH_TAGS_PAD: begin
					cls = CL_PAD;
					if (end4) go_tags = 1'b1;
				end
				PH_WORD: begin
					cls = (ck == K_INT) ? CL_INT : (ck == K_FLOAT) ? CL_FLOAT : CL_BSIZE;
					idx = cur_q;
					kind = ck;
					ws_n = w;
					if (end4) begin
						val = w;
						vld = 1'b1;
						ws_n = '0;
						if (ck == K_BLOB) begin
							if (w[31]) begin
								fcode = ST_NEG_BLOB;
							end else if (w == '0) begin
								go_arg = 1'b1;
							end else begin
								// Sizes past the packet limit never run down to zero.
								rem_n = (w[30:RemW] != '0) ? '1 : w[RemW-1:0];
								ph_n = PH_DATA;
							end
						end else begin
							go_arg = 1'b1;
						end
					end
				end
				PH_STR: begin
					idx = cur_q;
					kind = ck;
					if (data_byte == 8'h00) begin
						cls = CL_PAD;
						if (end4) go_arg = 1'b1; else ph_n = PH_ARG_PAD;
					end else begin
						cls = CL_STR;
						val = {24'd0, data_byte};
						vld = 1'b1;
					end
				end
				PH_DATA: begin
					cls = CL_BDATA;
					idx = cur_q;
					kind = ck;
					val = {24'd0, data_byte};
					vld = 1'b1;
					if (rem_q != '0) rem_n = rem_q - 1'b1;
					if (rem_n == '0) begin
						if (end4) go_arg = 1'b1; else ph_n = PH_ARG_PAD;
					end
				end
				PH_ARG_PAD: begin
					cls = CL_PAD;
					idx = cur_q;
					kind = ck;
					if (end4) go_arg = 1'b1;
				end
				default: begin
				end
			endcase

			if (go_addr) begin
				if (aempty_n) fcode = ST_EMPTY; else ph_n = PH_TAGS;
			end

			if (go_tags || go_arg) begin
				hit = go_arg ? hit_next : hit_zero;
				ek = store_q[hit.idx[TagIdxW-1:0]];
				if (go_tags && tbad_n) begin
					fcode = ST_BAD_TAGS;
				end else if (go_tags && tover_n) begin
					fcode = ST_TOO_MANY;
				end else begin
					cur_n = hit.idx;
					if (!hit.found) ph_n = PH_DONE;
					else if (ek == K_STR) ph_n = PH_STR;
					else if (ek == K_UNS) fcode = ST_UNS_TAG;
					else ph_n = PH_WORD;
				end
			end

			if (fcode != ST_OK) begin
				if (err_q == ST_OK) err_n = fcode;
				ph_n = PH_DONE;
			end
			pos_n = pos_q + 1'b1;
		end

		// A packet that ends early reports what was missing.
		if (last_byte && err_n == ST_OK) begin
			case (ph_n)
				PH_ADDR:     err_n = ST_UNTERM;
				PH_ADDR_PAD: err_n = ST_STR_PAD;
				PH_TAGS:     err_n = ST_UNTERM;
				PH_TAGS_PAD: err_n = ST_STR_PAD;
				PH_WORD:     err_n = ST_INT_SHORT;
				PH_STR:      err_n = ST_UNTERM;
				PH_DATA:     err_n = ST_BLOB_SHORT;
				PH_ARG_PAD: begin
					if ((cur_n < cnt_n && cur_n < TagCntW'(MaxTags)
							&& store_q[cur_n[TagIdxW-1:0]] == K_BLOB))
						err_n = ST_BLOB_PAD;
					else
						err_n = ST_STR_PAD;
				end
				default: begin
				end
			endcase
		end

		res.byte_class   = cls;
		res.atom_index   = idx[3:0];
		res.atom_kind    = kind;
		res.word_value   = val;
		res.word_valid   = vld;
		res.address_part = seg_n;
		res.status       = err_n;
	end

	always_ff @(posedge clk) begin
		if (en && wr_en) begin
			store_q[cnt_q[TagIdxW-1:0]] <= wr_kind;
			stop_q[cnt_q[TagIdxW-1:0]]  <= (wr_kind <= K_BLOB) || (wr_kind == K_UNS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_ADDR; pos_q <= '0; cnt_q <= '0; cur_q <= '0; ws_q <= '0;
			rem_q <= '0; err_q <= ST_OK; seg_q <= '0; bm_q <= '0; open_q <= 1'b0;
			aempty_q <= 1'b0; tbad_q <= 1'b0; tover_q <= 1'b0; tstart_q <= 1'b0;
		end else if (en) begin
			if (last_byte) begin
				ph_q <= PH_ADDR; pos_q <= '0; cnt_q <= '0; cur_q <= '0; ws_q <= '0;
				rem_q <= '0; err_q <= ST_OK; seg_q <= '0; bm_q <= '0; open_q <= 1'b0;
				aempty_q <= 1'b0; tbad_q <= 1'b0; tover_q <= 1'b0; tstart_q <= 1'b0;
			end else begin
				ph_q <= ph_n; pos_q <= pos_n; cnt_q <= cnt_n; cur_q <= cur_n; ws_q <= ws_n;
				rem_q <= rem_n; err_q <= err_n; seg_q <= seg_n; bm_q <= bm_n;
				open_q <= open_n; aempty_q <= aempty_n; tbad_q <= tbad_n;
				tover_q <= tover_n; tstart_q <= tstart_n;
			end
		end
	end

endmodule

// File: hw/rtl/osc_message_parser_top.sv
// Input and output registers hold each byte and its result. One byte per cycle
// while the sink takes results. The output register holds a waiting result, so a
// stalled sink stops the input only once the input register also holds a byte.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser
// to the start of a message; the parser also restarts after every last byte.
`include "osc_message_parser_top_macros.svh"
module osc_message_parser_top import osc_mp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] byte_class, [7:4] atom_index, [11:8] atom_kind, [43:12] word_value,
	// [44] word_valid, [51:45] address_part, [55:52] status
	output logic [55:0] m_tdata,
	output logic        m_tlast    // packet_done
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance;
	logic       out_valid_q;
	res_t       res;
	res_t       res_q;
	logic       done_q;
	logic       res_word_cls;
	logic       res_quiet;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	osc_mp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance) begin
			res_q  <= res;
			done_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.status, res_q.address_part, res_q.word_valid,
		res_q.word_value, res_q.atom_kind, res_q.atom_index, res_q.byte_class};
	assign m_tlast  = done_q;

	assign res_word_cls = res_q.byte_class inside {CL_INT, CL_FLOAT, CL_STR, CL_BSIZE, CL_BDATA};
	assign res_quiet    = !res_q.word_valid && res_q.atom_index == '0 && res_q.atom_kind == '0;

	`OSC_CHECK(a_word_class, m_tvalid && res_q.word_valid |-> res_word_cls, "word on a wrong class")
	`OSC_CHECK(a_ignored_quiet, m_tvalid && res_q.byte_class == CL_IGN |-> res_quiet, "ignored byte fields")
	`OSC_CHECK(a_s1_hold, valid_s1 && !advance |=> valid_s1 && $stable(data_s1), "stalled byte lost")

endmodule

// File: verif/tb_osc_message_parser_top.sv
// Self-checking testbench for the OSC message parser: byte stream in, one checked result per byte.
`timescale 1ns / 100ps
module tb_osc_message_parser_top;
	import osc_mp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;

	osc_message_parser_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct {
		res_t res;
		logic done;
	} parse_result_t;

	byte_item_t    pending_bytes[$];
	parse_result_t expected_results[$];
	int            fail_count = 0;
	int            packets_sent = 0;
	int            bytes_queued = 0;
	int            results_checked = 0;
	int            idle_cycles = 0;
	bit            calm_mode = 1'b0;
	bit            sender_hold = 1'b0;
	int            sink_hold = 0;
	bit            request_sink_hold = 1'b0;

	// Parser model state.
	logic [3:0]  m_phase;
	int unsigned m_pos;
	logic [3:0]  m_tags[MaxTags];
	int unsigned m_tag_cnt;
	int unsigned m_cur;
	logic [31:0] m_shift;
	int unsigned m_remain;
	logic [3:0]  m_err;
	logic [6:0]  m_segs;
	int unsigned m_bmatch;
	bit          m_seg_open, m_addr_empty, m_tag_bad, m_tag_over, m_tag_started;

	function automatic logic [3:0] tag_kind(input logic [7:0] c);
		case (c)
			"i": return K_INT;
			"f": return K_FLOAT;
			"s": return K_STR;
			"b": return K_BLOB;
			"T": return K_TRUE;
			"F": return K_FALSE;
			"N": return K_NIL;
			"I": return K_IMP;
			default: return K_UNS;
		endcase
	endfunction

	task automatic parser_clear();
		m_phase = PH_ADDR; m_pos = 0; m_tag_cnt = 0; m_cur = 0; m_shift = 0;
		m_remain = 0; m_err = ST_OK; m_segs = 0; m_bmatch = 0; m_seg_open = 0;
		m_addr_empty = 0; m_tag_bad = 0; m_tag_over = 0; m_tag_started = 0;
	endtask

	function automatic logic [3:0] cur_kind();
		if (m_cur < m_tag_cnt && m_cur < MaxTags) return m_tags[m_cur[TagIdxW-1:0]];
		return K_UNS;
	endfunction

	task automatic latch_error(input logic [3:0] code);
		if (m_err == ST_OK) m_err = code;
		m_phase = PH_DONE;
	endtask

	task automatic enter_argument();
		logic [3:0] k;
		while (m_cur < m_tag_cnt && m_cur < MaxTags) begin
			k = m_tags[m_cur[TagIdxW-1:0]];
			if (k == K_INT || k == K_FLOAT || k == K_BLOB) begin
				m_phase = PH_WORD;
				return;
			end
			if (k == K_STR) begin
				m_phase = PH_STR;
				return;
			end
			if (k == K_UNS) begin
				latch_error(ST_UNS_TAG);
				return;
			end
			m_cur++;
		end
		m_phase = PH_DONE;
	endtask

	task automatic next_argument();
		m_cur++;
		enter_argument();
	endtask

	task automatic close_address();
		if (m_addr_empty) latch_error(ST_EMPTY);
		else m_phase = PH_TAGS;
	endtask

	task automatic close_tags();
		if (m_tag_bad) latch_error(ST_BAD_TAGS);
		else if (m_tag_over) latch_error(ST_TOO_MANY);
		else begin
			m_cur = 0;
			enter_argument();
		end
	endtask

	task automatic predict_byte(input logic [7:0] d, input logic last);
		parse_result_t r;
		logic [3:0]  cls, kind;
		logic [31:0] idx, val;
		logic        vld;
		logic [3:0]  k;
		bit          end4;
		cls = CL_IGN; idx = 0; kind = 0; val = 0; vld = 0;
		end4 = (m_pos % 4) == 3;
		if (m_pos < MaxPacket) begin
			case (m_phase)
				PH_ADDR: begin
					if (d == 8'd0) begin
						cls = CL_PAD;
						m_addr_empty = (m_pos == 0);
						if (end4) close_address(); else m_phase = PH_ADDR_PAD;
					end else if (d == "/") begin
						cls = CL_SLASH;
						m_seg_open = 0;
					end else begin
						cls = CL_ADDR;
						if (!m_seg_open) begin
							m_seg_open = 1;
							if (m_segs < 127) m_segs++;
						end
					end
					if (m_pos < 7 && m_bmatch == m_pos && d == bundle_char(m_pos[2:0])) begin
						m_bmatch++;
						if (m_bmatch == 7) latch_error(ST_BUNDLE);
					end
				end
				PH_ADDR_PAD: begin
					cls = CL_PAD;
					if (end4) close_address();
				end
				PH_TAGS: begin
					if (d == 8'd0) begin
						cls = CL_PAD;
						if (!m_tag_started) m_tag_bad = 1;
						if (end4) close_tags(); else m_phase = PH_TAGS_PAD;
					end else begin
						cls = CL_TAG;
						if (!m_tag_started) begin
							m_tag_started = 1;
							if (d != ",") m_tag_bad = 1;
						end else begin
							k = tag_kind(d);
							idx = m_tag_cnt;
							kind = k;
							if (m_tag_cnt < MaxTags) begin
								m_tags[m_tag_cnt[TagIdxW-1:0]] = k;
								m_tag_cnt++;
							end else m_tag_over = 1;
						end
					end
				end
				PH_TAGS_PAD: begin
					cls = CL_PAD;
					if (end4) close_tags();
				end
				PH_WORD: begin
					k = cur_kind();
					cls = (k == K_INT) ? CL_INT : (k == K_FLOAT) ? CL_FLOAT : CL_BSIZE;
					idx = m_cur;
					kind = k;
					m_shift = {m_shift[23:0], d};
					if (end4) begin
						val = m_shift;
						vld = 1;
						m_shift = 0;
						if (k == K_BLOB) begin
							if (val[31]) latch_error(ST_NEG_BLOB);
							else if (val == 0) next_argument();
							else begin
								m_remain = val;
								m_phase = PH_DATA;
							end
						end else next_argument();
					end
				end
				PH_STR: begin
					idx = m_cur;
					kind = cur_kind();
					if (d == 8'd0) begin
						cls = CL_PAD;
						if (end4) next_argument(); else m_phase = PH_ARG_PAD;
					end else begin
						cls = CL_STR;
						val = {24'd0, d};
						vld = 1;
					end
				end
				PH_DATA: begin
					cls = CL_BDATA;
					idx = m_cur;
					kind = cur_kind();
					val = {24'd0, d};
					vld = 1;
					if (m_remain > 0) m_remain--;
					if (m_remain == 0) begin
						if (end4) next_argument(); else m_phase = PH_ARG_PAD;
					end
				end
				PH_ARG_PAD: begin
					cls = CL_PAD;
					idx = m_cur;
					kind = cur_kind();
					if (end4) next_argument();
				end
				default: ;
			endcase
			m_pos++;
		end
		if (last && m_err == ST_OK) begin
			case (m_phase)
				PH_ADDR, PH_TAGS, PH_STR: latch_error(ST_UNTERM);
				PH_ADDR_PAD, PH_TAGS_PAD: latch_error(ST_STR_PAD);
				PH_WORD: latch_error(ST_INT_SHORT);
				PH_DATA: latch_error(ST_BLOB_SHORT);
				PH_ARG_PAD: latch_error(cur_kind() == K_BLOB ? ST_BLOB_PAD : ST_STR_PAD);
				default: ;
			endcase
		end
		r.res.byte_class = cls;
		r.res.atom_index = idx[3:0];
		r.res.atom_kind = kind;
		r.res.word_value = val;
		r.res.word_valid = vld;
		r.res.address_part = m_segs;
		r.res.status = m_err;
		r.done = last;
		expected_results.insert(expected_results.size(), r);
		if (last) parser_clear();
	endtask

	// Packet construction helpers.
	byte_item_t pkt[$];

	task automatic put(input logic [7:0] b);
		byte_item_t it;
		it.data = b;
		it.last = 1'b0;
		pkt.insert(pkt.size(), it);
	endtask

	task automatic pad_to_word();
		while (pkt.size() % 4 != 0) put(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0);
	endtask

	task automatic put_string(input string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
		put(8'd0);
		pad_to_word();
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--) put(w[8*i +: 8]);
	endtask

	function automatic logic [7:0] rand_text_char();
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic put_random_string(input int maxlen);
		int n;
		n = $urandom_range(0, maxlen);
		for (int i = 0; i < n; i++) put(rand_text_char());
		put(8'd0);
		pad_to_word();
	endtask

	task automatic put_address();
		int nseg;
		nseg = $urandom_range(1, 4);
		for (int s = 0; s < nseg; s++) begin
			put("/");
			if ($urandom_range(0, 4) == 0) put("/");
			for (int i = 0; i < $urandom_range(1, 6); i++) put(8'($urandom_range(8'h30, 8'h7A)));
		end
		put(8'd0);
		pad_to_word();
	endtask

	// Send the built packet, optionally truncated, with last on its final byte.
	task automatic send_packet(input int trunc);
		int n;
		n = pkt.size();
		if (trunc > 0 && trunc < n) n = trunc;
		if (n == 0) put_random_string(0);
		if (n == 0) n = pkt.size();
		pkt[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) pending_bytes.insert(pending_bytes.size(), pkt[i]);
		pkt.delete();
		packets_sent++;
		bytes_queued += n;
	endtask

	task automatic build_message(input bit allow_odd);
		byte   tc[$];
		byte   t;
		int    ntag, bl;
		bit    fill;
		put_address();
		ntag = $urandom_range(0, ($urandom_range(0, 9) == 0) ? 19 : 6);
		put(",");
		for (int i = 0; i < ntag; i++) begin
			case ($urandom_range(0, allow_odd ? 9 : 8))
				0: t = "i";
				1: t = "f";
				2: t = "s";
				3: t = "b";
				4: t = "T";
				5: t = "F";
				6: t = "N";
				7: t = "I";
				8: t = "i";
				default: t = 8'($urandom_range(1, 255));
			endcase
			tc.insert(tc.size(), t);
			put(t);
		end
		put(8'd0);
		pad_to_word();
		foreach (tc[i]) begin
			case (tc[i])
				"i", "f": put_word($urandom);
				"s": put_random_string(7);
				"b": begin
					bl = $urandom_range(0, 6);
					if ($urandom_range(0, 15) == 0) put_word(32'h8000_0000 | $urandom);
					else begin
						put_word(bl);
						for (int j = 0; j < bl; j++) put(8'($urandom));
						pad_to_word();
					end
				end
				default: ;
			endcase
		end
		fill = $urandom_range(0, 5) == 0;
		if (fill) for (int j = 0; j < $urandom_range(1, 6); j++) put(8'($urandom));
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
	endtask

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata, s_tlast);
				void'(pending_bytes.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				// A beat that has not been taken stays on the bus unchanged.
				s_tvalid <= 1'b1;
			end else if (pending_bytes.size() != 0 && !sender_hold
					&& (calm_mode || $urandom_range(0, 99) >= 36)) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_bytes[0].data;
				s_tlast <= pending_bytes[0].last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor and sink.
	always @(posedge clk or negedge arst_n) begin
		parse_result_t exp_r;
		res_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_checked++;
				if (expected_results.size() == 0) begin
					$error("unexpected result beat %h", m_tdata);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.byte_class !== exp_r.res.byte_class) begin
						$error("byte_class exp %0d got %0d", exp_r.res.byte_class, got.byte_class);
						fail_count++;
					end
					if (got.atom_index !== exp_r.res.atom_index) begin
						$error("atom_index exp %0d got %0d", exp_r.res.atom_index, got.atom_index);
						fail_count++;
					end
					if (got.atom_kind !== exp_r.res.atom_kind) begin
						$error("atom_kind exp %0d got %0d", exp_r.res.atom_kind, got.atom_kind);
						fail_count++;
					end
					if (got.word_value !== exp_r.res.word_value) begin
						$error("word_value exp %h got %h", exp_r.res.word_value, got.word_value);
						fail_count++;
					end
					if (got.word_valid !== exp_r.res.word_valid) begin
						$error("word_valid exp %0d got %0d", exp_r.res.word_valid, got.word_valid);
						fail_count++;
					end
					if (got.address_part !== exp_r.res.address_part) begin
						$error("address_part exp %0d got %0d", exp_r.res.address_part,
							got.address_part);
						fail_count++;
					end
					if (got.status !== exp_r.res.status) begin
						$error("status exp %0d got %0d", exp_r.res.status, got.status);
						fail_count++;
					end
					if (m_tlast !== exp_r.done) begin
						$error("packet_done exp %0d got %0d", exp_r.done, m_tlast);
						fail_count++;
					end
				end
			end
			if (request_sink_hold && sink_hold == 0) sink_hold = 200;
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm_mode || ($urandom_range(0, 99) >= 36);
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("tb_osc_message_parser_top failed");
			$finish;
		end
	end

	initial begin
		parser_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed packets: one per special case.
		put_string("/a/b"); put(","); put("i"); put("f"); put(8'd0); pad_to_word();
		put_word(32'hFFFF_FFFF); put_word(32'h0); send_packet(0);
		put_string("#bundle"); put_word(0); send_packet(0);
		put_string(""); put_string(",i"); send_packet(0);
		put_string("/x"); put_string("zz"); send_packet(0);
		put_string("/x"); put(8'd0); put(8'd0); put(8'd0); put(8'd0); send_packet(0);
		put_string("/x"); put_string(",q"); send_packet(0);
		put_string("/x"); put_string(",ibs"); put_word(1); send_packet(6);
		put_string("/x"); put_string(",b"); put_word(32'h8000_0001); send_packet(0);
		put_string("/x"); put_string(",b"); put_word(3); put(8'd1); put(8'd2); put(8'd3);
		put(8'd0); send_packet(14);
		put_string("/x"); put_string(",b"); put_word(3); put(8'd1); put(8'd2); put(8'd3);
		put(8'd0); send_packet(15);
		put_string("/x"); put_string(",TFNIs"); put_string("hi"); send_packet(0);
		put_string("/x"); put_string(",s"); put_string("abcdef"); send_packet(13);
		put_string("/x"); put_string(",iiiiiiiiiiiiiiiii"); send_packet(0);
		put_string("/ab/"); send_packet(2);
		put_string("/ab"); send_packet(5);
		put(8'hFF); put(8'h00); send_packet(0);
		wait_drained();

		// Random messages, with a long stretch of back-to-back traffic.
		for (int p = 0; bytes_queued < 1200; p++) begin
			if (p % 25 == 0) wait_drained();
			calm_mode = (p >= 5 && p < 15);
			if (p == 16) begin
				request_sink_hold = 1'b1;
				wait (sink_hold != 0);
				request_sink_hold = 1'b0;
			end
			if (p == 20) begin
				sender_hold = 1'b1;
				while (expected_results.size() != 0) @(posedge clk);
				sender_hold = 1'b0;
			end
			if ($urandom_range(0, 9) == 0) begin
				for (int j = 0; j < $urandom_range(1, 12); j++) put(8'($urandom));
				send_packet(0);
			end else begin
				build_message(1'b1);
				send_packet(($urandom_range(0, 5) == 0) ? $urandom_range(1, pkt.size()) : 0);
			end
			while (pending_bytes.size() > 64) @(posedge clk);
		end
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d packets; %0d result beats were checked field by field.",
			packets_sent, results_checked);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("tb_osc_message_parser_top passed");
		else
			$display("tb_osc_message_parser_top failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/osc_mp_pkg.sv
hw/rtl/osc_mp_core.sv
hw/rtl/osc_message_parser_top.sv
verif/tb_osc_message_parser_top.sv
